>>> hdl/zrle_pkg.sv
// shared constants and types of the zero run-length encoder
`timescale 1ns / 1ps
`default_nettype none
package zrle_pkg;

	localparam int WORD_BITS   = 32;
	localparam int MAX_COLUMN  = 4096;
	localparam int POS_W       = 12;
	localparam int CNT_W       = 13;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;
	localparam int WIDX_W      = 3;

	localparam logic CFG_COMPLEX_MODE  = 1'b0;
	localparam logic CFG_COLUMN_LENGTH = 1'b1;

	// one classified element: what the back end has to emit for it
	typedef struct packed {
		logic                        flush;
		logic                        cplx;
		logic                        has_value;
		logic                        last;
		logic [CNT_W-1:0]            run;
		logic signed [WORD_BITS-1:0] re;
		logic signed [WORD_BITS-1:0] im;
	} cmd_t;

	// queue handshake towards the back end
	typedef struct packed {
		logic valid;
		logic pop;
	} qctl_t;

endpackage
`default_nettype wire

>>> hdl/zrle_ifs.sv
// request channels of the zero run-length encoder
`timescale 1ns / 1ps
`default_nettype none
interface zrle_in_if;
	logic                   valid;
	logic                   ready;
	logic signed [zrle_pkg::WORD_BITS-1:0] value_real;
	logic signed [zrle_pkg::WORD_BITS-1:0] value_imag;

	modport source (output valid, value_real, value_imag, input ready);
	modport sink (input valid, value_real, value_imag, output ready);
endinterface

interface zrle_out_if;
	logic                   valid;
	logic                   ready;
	logic signed [zrle_pkg::WORD_BITS-1:0] code_word;
	logic                   column_end;

	modport source (output valid, code_word, column_end, input ready);
	modport sink (input valid, code_word, column_end, output ready);
endinterface
`default_nettype wire

>>> hdl/zrle_front.sv
// front end: configuration, column position, zero run tracking, classification
`timescale 1ns / 1ps
`default_nettype none
module zrle_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [zrle_pkg::CNT_W-1:0]  cfg_wdata,
	input  wire logic                        accept,
	input  wire logic signed [zrle_pkg::WORD_BITS-1:0] value_real,
	input  wire logic signed [zrle_pkg::WORD_BITS-1:0] value_imag,
	output logic                             push,
	output zrle_pkg::cmd_t                   cmd
);

	logic                        complex_q;
	logic [zrle_pkg::CNT_W-1:0]  col_len_q;
	logic [zrle_pkg::POS_W-1:0]  pos_q;
	logic [zrle_pkg::CNT_W-1:0]  run_q;

	logic [zrle_pkg::CNT_W-1:0]  eff_len;
	logic [zrle_pkg::CNT_W-1:0]  pos_inc;
	logic [zrle_pkg::CNT_W-1:0]  run_inc;
	logic                        is_zero;
	logic                        last;

	always_comb begin
		if (col_len_q == '0) begin
			eff_len = zrle_pkg::CNT_W'(1);
		end else if (col_len_q > zrle_pkg::CNT_W'(zrle_pkg::MAX_COLUMN)) begin
			eff_len = zrle_pkg::CNT_W'(zrle_pkg::MAX_COLUMN);
		end else begin
			eff_len = col_len_q;
		end
		pos_inc = {1'b0, pos_q} + zrle_pkg::CNT_W'(1);
		run_inc = run_q + zrle_pkg::CNT_W'(1);
		last    = pos_inc >= eff_len;
		is_zero = (value_real == '0) && (!complex_q || value_imag == '0);

		cmd.cplx      = complex_q;
		cmd.last      = last;
		cmd.re        = value_real;
		cmd.im        = value_imag;
		cmd.has_value = !is_zero;
		if (is_zero) begin
			cmd.flush = last;
			cmd.run   = run_inc;
		end else begin
			cmd.flush = run_q != '0;
			cmd.run   = run_q;
		end
		// a zero inside the column produces nothing yet
		push = accept && (!is_zero || last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			complex_q <= 1'b0;
			col_len_q <= zrle_pkg::CNT_W'(1);
			pos_q     <= '0;
			run_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					zrle_pkg::CFG_COMPLEX_MODE:  complex_q <= cfg_wdata[0];
					zrle_pkg::CFG_COLUMN_LENGTH: col_len_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (accept) begin
				if (last) begin
					pos_q <= '0;
					run_q <= '0;
				end else begin
					pos_q <= pos_inc[zrle_pkg::POS_W-1:0];
					run_q <= is_zero ? run_inc : '0;
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/zrle_queue.sv
// short command queue between front and back end
`timescale 1ns / 1ps
`default_nettype none
module zrle_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire zrle_pkg::cmd_t push_cmd,
	output logic                full,
	input  wire logic           pop,
	output logic                head_valid,
	output zrle_pkg::cmd_t      head_cmd
);

	zrle_pkg::cmd_t                   mem_q [zrle_pkg::QUEUE_DEPTH];
	logic [zrle_pkg::QUEUE_AW-1:0]    wr_q;
	logic [zrle_pkg::QUEUE_AW-1:0]    rd_q;
	logic [zrle_pkg::QUEUE_AW:0]      count_q;

	assign full       = count_q == (zrle_pkg::QUEUE_AW+1)'(zrle_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_cmd   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + zrle_pkg::QUEUE_AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + zrle_pkg::QUEUE_AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (zrle_pkg::QUEUE_AW+1)'(1);
				2'b01:   count_q <= count_q - (zrle_pkg::QUEUE_AW+1)'(1);
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hdl/zrle_back.sv
// back end: walks the words of each command into the output register
`timescale 1ns / 1ps
`default_nettype none
module zrle_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           head_valid,
	input  wire zrle_pkg::cmd_t head_cmd,
	output zrle_pkg::qctl_t     qctl,
	zrle_out_if.source          out_ch
);

	logic [zrle_pkg::WIDX_W-1:0]          idx_q;
	logic                                 valid_q;
	logic signed [zrle_pkg::WORD_BITS-1:0] word_q;
	logic                                 end_q;

	logic [zrle_pkg::WIDX_W-1:0]          base;
	logic [zrle_pkg::WIDX_W-1:0]          nwords;
	logic                                 final_word;
	logic                                 adv;
	logic signed [zrle_pkg::WORD_BITS-1:0] word;

	always_comb begin
		// marker word(s) and length first, then value word(s)
		if (head_cmd.flush) begin
			base = head_cmd.cplx ? zrle_pkg::WIDX_W'(3) : zrle_pkg::WIDX_W'(2);
		end else begin
			base = '0;
		end
		if (head_cmd.has_value) begin
			nwords = base + (head_cmd.cplx ? zrle_pkg::WIDX_W'(2) : zrle_pkg::WIDX_W'(1));
		end else begin
			nwords = base;
		end
		final_word = idx_q == nwords - zrle_pkg::WIDX_W'(1);
		if (idx_q < base) begin
			if (idx_q == base - zrle_pkg::WIDX_W'(1)) begin
				word = $signed({{(zrle_pkg::WORD_BITS-zrle_pkg::CNT_W){1'b0}},
					head_cmd.run});
			end else begin
				word = '0;
			end
		end else if (idx_q == base) begin
			word = head_cmd.re;
		end else begin
			word = head_cmd.im;
		end
		adv        = head_valid && (!valid_q || out_ch.ready);
		qctl.valid = head_valid;
		qctl.pop   = adv && final_word;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			word_q <= word;
			end_q  <= head_cmd.last && final_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (adv) begin
				idx_q   <= final_word ? '0 : idx_q + zrle_pkg::WIDX_W'(1);
				valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid      = valid_q;
	assign out_ch.code_word  = word_q;
	assign out_ch.column_end = end_q;

endmodule
`default_nettype wire

>>> hdl/zero_run_length_encoder.sv
// top level of the zero run-length encoder
`timescale 1ns / 1ps
`default_nettype none
// Compresses matrix columns one element per input request. A nonzero element
// leaves as one word (real mode) or two words, real then imaginary (complex
// mode). A run of zero elements leaves as a zero marker (one or two zero words)
// followed by the run length, when the next nonzero element arrives or the
// column ends; column_end flags the last word of each column. An element of
// zero inside a column produces no output yet. The front end takes one input
// request every cycle while its four-entry command queue has room; the back
// end sends one output word per cycle while the receiver is ready; an element
// produces one to five words, and a zero inside a column costs nothing at the
// output. Throughput is therefore set by the single output word register.
// Configuration: index 0 is complex_mode (bit 0), index 1 is column_length
// (13 bits, 0 acts as 1, above 4096 acts as 4096); write only while idle.
module zero_run_length_encoder (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [zrle_pkg::CNT_W-1:0]  cfg_wdata,
	zrle_in_if.sink                          in_ch,
	zrle_out_if.source                       out_ch
);

	logic            accept;
	logic            push;
	logic            full;
	zrle_pkg::cmd_t  push_cmd;
	zrle_pkg::cmd_t  head_cmd;
	logic            head_valid;
	zrle_pkg::qctl_t qctl;

	// input request taken whenever the queue has a free slot
	assign in_ch.ready = !full;
	assign accept      = in_ch.valid && !full;

	zrle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.accept     (accept),
		.value_real (in_ch.value_real),
		.value_imag (in_ch.value_imag),
		.push       (push),
		.cmd        (push_cmd)
	);

	// decouples classification from word emission
	zrle_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.pop        (qctl.pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	zrle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.qctl       (qctl),
		.out_ch     (out_ch)
	);

	// no command pushed into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("command queue overflow");

	// back end only retires a command that is present
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		qctl.pop |-> qctl.valid)
		else $error("command queue underflow");

	// retiring a command always leaves its last word on the output
	a_pop_shows_word: assert property (@(posedge clk) disable iff (!arst_n)
		qctl.pop |=> out_ch.valid)
		else $error("retired command produced no output word");

endmodule
`default_nettype wire

>>> bench/zero_run_length_encoder_test.sv
// testbench of the zero run-length encoder: directed and random columns checked word by word
`timescale 1ns / 1ps
module zero_run_length_encoder_test;

	localparam int CYCLE_LIMIT    = 500000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int LONG_HOLD      = 300;
	localparam int RANDOM_PHASES  = 12;
	localparam int PHASE_ELEMENTS = 34;

	typedef logic signed [zrle_pkg::WORD_BITS-1:0] word_t;

	// one column element waiting to be offered, with its stimulus marks
	typedef struct {
		word_t re;
		word_t im;
		bit    hold_receiver;
		bit    drain_first;
	} element_t;

	// one predicted word of the compressed stream
	typedef struct {
		word_t code_word;
		logic  column_end;
	} code_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic                       cfg_index;
	logic [zrle_pkg::CNT_W-1:0] cfg_wdata;

	zrle_in_if  in_ch();
	zrle_out_if out_ch();

	zero_run_length_encoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	element_t pending_elements[$];
	code_t    predicted_words[$];
	element_t offered;
	code_t    want;

	// encoder state as predicted, plus our copy of the registers
	logic                       model_complex;
	logic [zrle_pkg::CNT_W-1:0] model_length;
	logic [zrle_pkg::POS_W-1:0] model_position;
	logic [zrle_pkg::CNT_W-1:0] model_run;

	// idling controls, switched per phase by the stimulus
	bit tx_idle_on;
	bit rx_idle_on;
	int tx_gap_left;
	int rx_gap_left;
	int rx_hold_left;
	int hold_requests;
	int holds_taken;

	int failures;
	int elements_sent;
	int words_checked;
	int settings_used;
	int cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// works out the words one accepted element causes and queues them
	function automatic void encode_element(word_t re, word_t im);
		int    eff_len;
		int    n;
		bit    is_zero;
		bit    last;
		word_t burst[5];
		code_t c;
		eff_len = int'(model_length);
		if (eff_len < 1)
			eff_len = 1;
		if (eff_len > zrle_pkg::MAX_COLUMN)
			eff_len = zrle_pkg::MAX_COLUMN;
		// in complex mode both halves must be zero
		is_zero = model_complex ? (re == 0 && im == 0) : (re == 0);
		last = (int'(model_position) + 1) >= eff_len;
		n = 0;
		if (is_zero)
			model_run = model_run + 1'b1;
		// run closes on a nonzero element or at the column end
		if ((is_zero && last) || (!is_zero && model_run != 0)) begin
			burst[n] = '0;
			n = n + 1;
			if (model_complex) begin
				burst[n] = '0;
				n = n + 1;
			end
			burst[n] = zrle_pkg::WORD_BITS'(model_run);
			n = n + 1;
			model_run = '0;
		end
		if (!is_zero) begin
			burst[n] = re;
			n = n + 1;
			if (model_complex) begin
				burst[n] = im;
				n = n + 1;
			end
		end
		for (int i = 0; i < n; i++) begin
			c.code_word  = burst[i];
			c.column_end = last && (i == n - 1);
			predicted_words.push_back(c);
		end
		if (last) begin
			model_position = '0;
			model_run      = '0;
		end else begin
			model_position = model_position + 1'b1;
		end
	endfunction

	// extremes, small signed values and full random words
	function automatic word_t random_word();
		word_t w;
		case ($urandom_range(0, 7))
			0: w = {1'b0, {(zrle_pkg::WORD_BITS-1){1'b1}}};
			1: w = {1'b1, {(zrle_pkg::WORD_BITS-1){1'b0}}};
			2: w = '1;
			3, 4: begin
				w = $urandom_range(1, 20);
				if ($urandom_range(0, 1))
					w = -w;
			end
			default: w = $urandom();
		endcase
		return w;
	endfunction

	// zero elements are common; in complex mode half-zero pairs too
	function automatic element_t random_element(bit cplx);
		element_t e;
		int       pick;
		e.re            = random_word();
		e.im            = random_word();
		e.hold_receiver = 1'b0;
		e.drain_first   = 1'b0;
		pick = $urandom_range(0, 19);
		if (cplx) begin
			if (pick < 6) begin
				e.re = '0;
				e.im = '0;
			end else if (pick < 9) begin
				e.re = '0;
			end else if (pick < 12) begin
				e.im = '0;
			end
		end else if (pick < 8) begin
			e.re = '0;
		end
		return e;
	endfunction

	function automatic void add_element(word_t re, word_t im);
		element_t e;
		e.re            = re;
		e.im            = im;
		e.hold_receiver = 1'b0;
		e.drain_first   = 1'b0;
		pending_elements.push_back(e);
	endfunction

	// register write; only called while the encoder is idle
	task automatic write_register(logic index, logic [zrle_pkg::CNT_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == zrle_pkg::CFG_COMPLEX_MODE)
			model_complex = data[0];
		else
			model_length = data;
	endtask

	// everything offered and every predicted word seen, then let zero elements drain
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_elements.size() != 0 || in_ch.valid || predicted_words.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		settings_used++;
	endtask

	// request driver: holds an offer until taken, random gaps between offers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid      <= 1'b0;
			in_ch.value_real <= '0;
			in_ch.value_imag <= '0;
			tx_gap_left = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				encode_element(in_ch.value_real, in_ch.value_imag);
				elements_sent++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (tx_gap_left > 0) begin
					tx_gap_left--;
					in_ch.valid <= 1'b0;
				end else if (pending_elements.size() == 0) begin
					in_ch.valid <= 1'b0;
				end else if (pending_elements[0].drain_first
					&& predicted_words.size() != 0) begin
					// sender pause: hold back until the output side has caught up
					in_ch.valid <= 1'b0;
				end else if (tx_idle_on && $urandom_range(0, 5) == 0) begin
					tx_gap_left = $urandom_range(1, 13) - 1;
					in_ch.valid <= 1'b0;
				end else begin
					offered = pending_elements.pop_front();
					// ask the receiver for its long hold-off from this request on
					if (offered.hold_receiver)
						hold_requests++;
					in_ch.valid      <= 1'b1;
					in_ch.value_real <= offered.re;
					in_ch.value_imag <= offered.im;
				end
			end
		end
	end

	// output monitor: checks each taken word, drives ready with stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			rx_gap_left  = 0;
			rx_hold_left = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (predicted_words.size() == 0) begin
					failures++;
					$display("%0t: unexpected word, expected none, actual %h column_end %b",
						$time, out_ch.code_word, out_ch.column_end);
				end else begin
					want = predicted_words.pop_front();
					words_checked++;
					if (out_ch.code_word !== want.code_word) begin
						failures++;
						$display("%0t: code_word expected %h actual %h",
							$time, want.code_word, out_ch.code_word);
					end
					if (out_ch.column_end !== want.column_end) begin
						failures++;
						$display("%0t: column_end expected %b actual %b",
							$time, want.column_end, out_ch.column_end);
					end
				end
			end
			if (holds_taken != hold_requests) begin
				holds_taken  = hold_requests;
				rx_hold_left = LONG_HOLD;
			end
			if (rx_hold_left > 0) begin
				// long stall so the command queue fills and input backs up
				rx_hold_left--;
				out_ch.ready <= 1'b0;
			end else if (rx_gap_left > 0) begin
				rx_gap_left--;
				out_ch.ready <= 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				rx_gap_left = $urandom_range(1, 13) - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		element_t e;
		int       k;
		int       streak;
		bit       hold_marked;
		bit       drain_marked;
		cfg_we           = 1'b0;
		cfg_index        = zrle_pkg::CFG_COMPLEX_MODE;
		cfg_wdata        = '0;
		// register and state values after reset
		model_complex  = 1'b0;
		model_length   = 1;
		model_position = '0;
		model_run      = '0;
		tx_idle_on     = 1'b1;
		rx_idle_on     = 1'b1;
		hold_requests  = 0;
		holds_taken    = 0;
		failures       = 0;
		elements_sent  = 0;
		words_checked  = 0;
		settings_used  = 0;
		cycles         = 0;
		hold_marked    = 1'b0;
		drain_marked   = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: real mode, one element per column, so every element ends a column
		add_element('0, 32'sh12345678);
		add_element({1'b0, {(zrle_pkg::WORD_BITS-1){1'b1}}}, '0);
		add_element({1'b1, {(zrle_pkg::WORD_BITS-1){1'b0}}}, '1);
		add_element('1, 32'sh00000005);
		wait_idle();

		// complex pairs, length 0 behaves as 1; half-zero pairs count as nonzero
		write_register(zrle_pkg::CFG_COMPLEX_MODE, 1);
		write_register(zrle_pkg::CFG_COLUMN_LENGTH, 0);
		add_element('0, '0);
		add_element('0, {1'b1, {(zrle_pkg::WORD_BITS-1){1'b0}}});
		add_element({1'b0, {(zrle_pkg::WORD_BITS-1){1'b1}}}, '0);
		add_element('1, '1);
		wait_idle();

		// real columns of four: a run closed by a value, then one flushed at the end
		write_register(zrle_pkg::CFG_COMPLEX_MODE, 0);
		write_register(zrle_pkg::CFG_COLUMN_LENGTH, 4);
		add_element('0, 32'sh0000abcd);
		add_element('0, '0);
		add_element(7, '1);
		add_element('0, '0);
		wait_idle();

		// complex columns of five: value after a run gives the five-word burst
		write_register(zrle_pkg::CFG_COMPLEX_MODE, 1);
		write_register(zrle_pkg::CFG_COLUMN_LENGTH, 5);
		add_element('0, '0);
		add_element('0, '0);
		add_element(1, -2);
		add_element('0, '0);
		add_element(3, '0);
		// leave a run open across the mode switch
		add_element('0, '0);
		add_element('0, '0);
		wait_idle();

		// back to real mode mid-run: the flush uses the single-word marker
		write_register(zrle_pkg::CFG_COMPLEX_MODE, 0);
		add_element('0, 32'sh00000001);
		add_element(9, '0);
		add_element('0, '0);
		wait_idle();

		// long column part-filled, then length lowered below the position
		write_register(zrle_pkg::CFG_COLUMN_LENGTH, zrle_pkg::MAX_COLUMN);
		add_element(1, '0);
		add_element('0, '0);
		add_element('0, '0);
		add_element(2, '0);
		add_element('0, '0);
		wait_idle();
		write_register(zrle_pkg::CFG_COLUMN_LENGTH, 3);
		add_element('0, '0);
		wait_idle();

		// length just above the maximum saturates; twelve-bit wrapping would end
		// the column after three elements, so six pass without an end
		write_register(zrle_pkg::CFG_COMPLEX_MODE, 1);
		write_register(zrle_pkg::CFG_COLUMN_LENGTH, 13'd4099);
		add_element('0, '0);
		add_element('0, '0);
		add_element(5, '0);
		add_element('0, 32'sh00000009);
		add_element('0, '0);
		add_element('0, '0);
		wait_idle();
		// lowering the length closes the column with the run still open
		write_register(zrle_pkg::CFG_COLUMN_LENGTH, 2);
		add_element('0, '0);
		wait_idle();

		// random phases; idling off for a middle stretch and for the final phase
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			tx_idle_on = !(p == 4 || p == RANDOM_PHASES - 1);
			rx_idle_on = tx_idle_on;
			write_register(zrle_pkg::CFG_COMPLEX_MODE, $urandom_range(0, 1));
			case ($urandom_range(0, 4))
				0: write_register(zrle_pkg::CFG_COLUMN_LENGTH, $urandom_range(0, 2));
				1: write_register(zrle_pkg::CFG_COLUMN_LENGTH, $urandom_range(3, 8));
				2: write_register(zrle_pkg::CFG_COLUMN_LENGTH, $urandom_range(9, 40));
				3: ; // keep the length, columns carry on from the last phase
				default: write_register(zrle_pkg::CFG_COLUMN_LENGTH, $urandom_range(1, 8));
			endcase
			k = 0;
			while (k < PHASE_ELEMENTS) begin
				if ($urandom_range(0, 9) == 0) begin
					// burst of zero elements for longer runs
					streak = $urandom_range(2, 10);
					repeat (streak) begin
						e.re            = '0;
						e.im            = model_complex ? word_t'(0) : random_word();
						e.hold_receiver = 1'b0;
						e.drain_first   = 1'b0;
						pending_elements.push_back(e);
					end
					k += streak;
				end else begin
					e = random_element(model_complex);
					if (p == 2 && k >= 3 && !hold_marked) begin
						e.hold_receiver = 1'b1;
						hold_marked     = 1'b1;
					end
					if (p == 5 && k >= 15 && !drain_marked) begin
						e.drain_first = 1'b1;
						drain_marked  = 1'b1;
					end
					pending_elements.push_back(e);
					k++;
				end
			end
			wait_idle();
		end

		$display("%0d column elements sent under %0d register settings, %0d code words checked",
			elements_sent, settings_used, words_checked);
		$display("covered saturated and zero lengths, mode and length changes mid-column, stalls");
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> sim.f
hdl/zrle_pkg.sv
hdl/zrle_ifs.sv
hdl/zrle_front.sv
hdl/zrle_queue.sv
hdl/zrle_back.sv
hdl/zero_run_length_encoder.sv
bench/zero_run_length_encoder_test.sv
